// ===== hdl/pid_controller_antiwindup_slew_unit_assert.svh =====
// Assertion macros shared by the PID controller RTL
`ifndef PID_CONTROLLER_ANTIWINDUP_SLEW_UNIT_ASSERT_SVH
`define PID_CONTROLLER_ANTIWINDUP_SLEW_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PID_AWS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PID_AWS_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PID_AWS_ASSERT(label, clk, rst, prop, msg)
`define PID_AWS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== hdl/pid_aws_pkg.sv =====
// Types, widths, codes and helpers for the PID controller
package pid_aws_pkg;

   localparam int DATA_WIDTH = 16;

   localparam int IN_W       = 16;
   localparam int OUT_W      = 16;
   localparam int LIM_W      = 15;
   localparam int GAIN_W     = 32;
   localparam int HALF_W     = 16;
   localparam int FRAC_W     = 16;
   localparam int ERR_W      = 17;
   localparam int DERR_W     = 18;
   localparam int SUM_W      = 32;
   localparam int SUMX_W     = 36;
   localparam int MUL_A_W    = 33;
   localparam int PROD_W     = MUL_A_W + HALF_W + 1;
   localparam int ACC_W      = 52;
   localparam int QUO_W      = 34;
   localparam int LOW_MAG_W  = QUO_W - FRAC_W;
   localparam int HI_W       = ACC_W - LOW_MAG_W;
   localparam int QCNT_W     = $clog2(QUO_W + 1);
   localparam int MUL_STEPS  = 6;
   localparam int MCNT_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int SLEW_W     = ((DATA_WIDTH > OUT_W) ? DATA_WIDTH : OUT_W) + 2;

   localparam logic [QUO_W-1:0] SCALE_CAP = QUO_W'(64'h2_0000_0000);

   localparam logic signed [SLEW_W-1:0] SAT_HI =
      SLEW_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
   localparam logic signed [SLEW_W-1:0] SAT_LO = ~SAT_HI;

   localparam logic [GAIN_W-1:0]       KP_RST         = '0;
   localparam logic [GAIN_W-1:0]       KI_TS_RST      = '0;
   localparam logic [GAIN_W-1:0]       KD_F_RST       = '0;
   localparam logic [LIM_W-1:0]        MAX_OUTPUT_RST = 15'd32767;
   localparam logic signed [OUT_W-1:0] MIN_OUTPUT_RST = 16'sh8000;
   localparam logic [LIM_W-1:0]        SLEW_STEP_RST  = 15'd25;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KP,
      CSR_KI_TS,
      CSR_KD_F,
      CSR_MAX_OUTPUT,
      CSR_MIN_OUTPUT,
      CSR_SLEW_STEP
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_MUL,
      ST_CLAMP,
      ST_DIV,
      ST_UNWIND,
      ST_SLEW,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Saturate a widened sum back to the signed 32-bit integral range
   function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUMX_W-1:0] v);
      logic signed [SUM_W-1:0] r;
      if (v[SUMX_W-1:SUM_W-1] == '0 || v[SUMX_W-1:SUM_W-1] == '1) begin
         r = v[SUM_W-1:0];
      end else if (v[SUMX_W-1]) begin
         r = {1'b1, {(SUM_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(SUM_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

// ===== hdl/pid_controller_antiwindup_slew_unit.sv =====
// PID controller with back-calculation anti-windup and output slew limit
// Sequence: sum, multiply, clamp, slew, done; a restart transaction goes straight
//   from sum to done, and an integral unwind adds a 34-step serial divide plus handoff.
// A new request is taken only in idle, once the previous result has been handed off; the
//   work runs as six passes through the shared 33x17 multiplier and the bit-serial divider.
// Reset: gains zero, limits +32767/-32768, slew step 25, integral and history cleared.
`include "pid_controller_antiwindup_slew_unit_assert.svh"
module pid_controller_antiwindup_slew_unit (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic signed [pid_aws_pkg::IN_W-1:0]       req_setpoint,
   input  logic signed [pid_aws_pkg::IN_W-1:0]       req_measurement,
   input  logic                                      req_restart,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [pid_aws_pkg::OUT_W-1:0]      rsp_drive,
   output logic                                      rsp_limit_hit,
   output logic                                      rsp_slew_hit,
   input  logic                                      csr_wr_en,
   input  logic [pid_aws_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [pid_aws_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import pid_aws_pkg::*;

   // configuration
   logic [GAIN_W-1:0]       kp_ff, ki_ff, kd_ff;
   logic [LIM_W-1:0]        max_ff, step_ff;
   logic signed [OUT_W-1:0] min_ff;

   // sequencer
   state_type         state_ff, state_in;
   logic [MCNT_W-1:0] mcnt_ff, mcnt_in;

   // controller state
   logic signed [SUM_W-1:0]      sum_ff, sum_in;
   logic signed [ERR_W-1:0]      prev_err_ff, prev_err_in;
   logic signed [DATA_WIDTH-1:0] prev_out_ff, prev_out_in;

   // working registers
   logic signed [ERR_W-1:0]  err_ff, err_in;
   logic                     restart_ff, restart_in;
   logic signed [DERR_W-1:0] derr_ff, derr_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [OUT_W-1:0]  o_ff, o_in;
   logic                     lim_ff, lim_in;
   logic [ACC_W-1:0]         mag_ff, mag_in;
   logic                     neg_ff, neg_in;
   logic signed [OUT_W-1:0]  drive_ff, drive_in;
   logic                     slw_ff, slw_in;

   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0] rsp_drive_ff, rsp_drive_in;
   logic                    rsp_lim_ff, rsp_lim_in;
   logic                    rsp_slw_ff, rsp_slw_in;

   // control
   logic accept;
   logic div_start;
   logic rsp_load;

   // shared units
   logic signed [MUL_A_W-1:0] mul_a;
   logic [HALF_W-1:0]         mul_b;
   logic signed [PROD_W-1:0]  mul_prod;
   logic [QUO_W-1:0]          div_q;
   div_status_type            div_stat;

   // datapath terms
   logic signed [ERR_W-1:0]  err_new;
   logic signed [SUM_W-1:0]  sum_acc;
   logic signed [DERR_W-1:0] derr_new;
   logic                     ki_nz;
   logic signed [ACC_W-1:0]  acc_add;
   logic signed [ACC_W-1:0]  max_ext, min_ext, negmax;
   logic                     over, under, under_sym;
   logic                     unwind_c, lim_c, neg_c;
   logic signed [OUT_W-1:0]  o_c;
   logic [ACC_W-1:0]         mag_c;
   logic signed [SUMX_W-1:0] q_ext;
   logic signed [SUM_W-1:0]  sum_unw;
   logic signed [SLEW_W-1:0] o_w, last_w, step_w, diff, slewed, sat_w;
   logic                     up, dn;

   pid_aws_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (mul_prod)
   );

   pid_aws_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .magnitude (mag_c),
      .divisor   (ki_ff),
      .quotient  (div_q),
      .status    (div_stat)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff   <= KP_RST;
         ki_ff   <= KI_TS_RST;
         kd_ff   <= KD_F_RST;
         max_ff  <= MAX_OUTPUT_RST;
         min_ff  <= MIN_OUTPUT_RST;
         step_ff <= SLEW_STEP_RST;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_KP:         kp_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_KI_TS:      ki_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_KD_F:       kd_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_MAX_OUTPUT: max_ff  <= csr_wdata[LIM_W-1:0];
            CSR_MIN_OUTPUT: min_ff  <= csr_wdata[OUT_W-1:0];
            CSR_SLEW_STEP:  step_ff <= csr_wdata[LIM_W-1:0];
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   // error, integral and derivative terms
   assign err_new  = ERR_W'(req_setpoint) - ERR_W'(req_measurement);
   assign ki_nz    = (ki_ff != '0);
   assign sum_acc  = sat_sum(SUMX_W'(sum_ff) + SUMX_W'(err_ff));
   assign derr_new = DERR_W'(err_ff) - DERR_W'(prev_err_ff);

   // operand select: even pass takes the gain's low half, odd pass its high half
   always_comb begin
      case (mcnt_ff[MCNT_W-1:1])
         2'd0:    mul_a = MUL_A_W'(err_ff);
         2'd1:    mul_a = MUL_A_W'(sum_ff);
         2'd2:    mul_a = MUL_A_W'(derr_ff);
         default: mul_a = '0;
      endcase
      case (mcnt_ff[MCNT_W-1:1])
         2'd0:    mul_b = mcnt_ff[0] ? kp_ff[GAIN_W-1:HALF_W] : kp_ff[HALF_W-1:0];
         2'd1:    mul_b = mcnt_ff[0] ? ki_ff[GAIN_W-1:HALF_W] : ki_ff[HALF_W-1:0];
         2'd2:    mul_b = mcnt_ff[0] ? kd_ff[GAIN_W-1:HALF_W] : kd_ff[HALF_W-1:0];
         default: mul_b = '0;
      endcase
   end

   // floor(x*g >> 16) = floor(x*g_lo >> 16) + x*g_hi; the product arrives in the cycle after issue
   assign acc_add = mcnt_ff[0] ? ACC_W'(mul_prod >>> FRAC_W) : ACC_W'(mul_prod);

   // output limits
   assign max_ext   = ACC_W'({1'b0, max_ff});
   assign min_ext   = ACC_W'(min_ff);
   assign negmax    = -max_ext;
   assign over      = acc_ff > max_ext;
   assign under     = acc_ff < min_ext;
   assign under_sym = acc_ff < negmax;

   always_comb begin
      unwind_c = 1'b0;
      lim_c    = 1'b0;
      neg_c    = 1'b0;
      o_c      = OUT_W'(acc_ff);
      mag_c    = acc_ff - max_ext;
      if (ki_nz) begin
         if (over) begin
            unwind_c = 1'b1;
            lim_c    = 1'b1;
            o_c      = OUT_W'(max_ext);
         end else if (under) begin
            unwind_c = 1'b1;
            lim_c    = 1'b1;
            neg_c    = 1'b1;
            o_c      = min_ff;
            mag_c    = min_ext - acc_ff;
         end
      end else if (over) begin
         lim_c = 1'b1;
         o_c   = OUT_W'(max_ext);
      end else if (under_sym) begin
         lim_c = 1'b1;
         o_c   = OUT_W'(negmax);
      end
   end

   // back-calculation: pull the sum back by the scaled excess
   assign q_ext   = {2'b00, div_q};
   assign sum_unw = sat_sum(neg_ff ? SUMX_W'(sum_ff) + q_ext : SUMX_W'(sum_ff) - q_ext);

   // slew limit, then saturate to the output word
   assign o_w    = SLEW_W'(o_ff);
   assign last_w = SLEW_W'(prev_out_ff);
   assign step_w = SLEW_W'({1'b0, step_ff});
   assign diff   = o_w - last_w;
   assign up     = diff > step_w;
   assign dn     = diff < -step_w;
   assign slewed = up ? last_w + step_w : (dn ? last_w - step_w : o_w);
   assign sat_w  = (slewed > SAT_HI) ? SAT_HI : ((slewed < SAT_LO) ? SAT_LO : slewed);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_SUM;
         ST_SUM:    state_in = restart_ff ? ST_DONE : ST_MUL;
         ST_MUL:    if (mcnt_ff == MCNT_W'(MUL_STEPS)) state_in = ST_CLAMP;
         ST_CLAMP:  state_in = unwind_c ? ST_DIV : ST_SLEW;
         ST_DIV:    if (div_stat.done) state_in = ST_UNWIND;
         ST_UNWIND: state_in = ST_SLEW;
         ST_SLEW:   state_in = ST_DONE;
         ST_DONE:   if (rsp_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      accept    = req_valid && (state_ff == ST_IDLE);
      div_start = (state_ff == ST_CLAMP) && unwind_c;
      rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   // datapath next values
   always_comb begin
      mcnt_in     = mcnt_ff;
      sum_in      = sum_ff;
      prev_err_in = prev_err_ff;
      prev_out_in = prev_out_ff;
      err_in      = err_ff;
      restart_in  = restart_ff;
      derr_in     = derr_ff;
      acc_in      = acc_ff;
      o_in        = o_ff;
      lim_in      = lim_ff;
      mag_in      = mag_ff;
      neg_in      = neg_ff;
      drive_in    = drive_ff;
      slw_in      = slw_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               err_in     = err_new;
               restart_in = req_restart;
            end
         end
         ST_SUM: begin
            if (restart_ff) begin
               sum_in      = '0;
               prev_err_in = '0;
               prev_out_in = '0;
               drive_in    = '0;
               lim_in      = 1'b0;
               slw_in      = 1'b0;
            end else begin
               sum_in  = ki_nz ? sum_acc : '0;
               derr_in = derr_new;
               acc_in  = '0;
               mcnt_in = '0;
            end
         end
         ST_MUL: begin
            mcnt_in = mcnt_ff + MCNT_W'(1);
            if (mcnt_ff != '0) begin
               acc_in = acc_ff + acc_add;
            end
         end
         ST_CLAMP: begin
            o_in        = o_c;
            lim_in      = lim_c;
            mag_in      = mag_c;
            neg_in      = neg_c;
            prev_err_in = err_ff;
         end
         ST_UNWIND: begin
            sum_in = sum_unw;
         end
         ST_SLEW: begin
            drive_in    = OUT_W'(sat_w);
            slw_in      = up || dn;
            prev_out_in = DATA_WIDTH'(sat_w);
         end
         default: begin
            // hold
         end
      endcase
   end

   // response register: a finished result waits here while the next transaction starts
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_drive_in = rsp_drive_ff;
      rsp_lim_in   = rsp_lim_ff;
      rsp_slw_in   = rsp_slw_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_drive_in = drive_ff;
         rsp_lim_in   = lim_ff;
         rsp_slw_in   = slw_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mcnt_ff      <= '0;
         sum_ff       <= '0;
         prev_err_ff  <= '0;
         prev_out_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mcnt_ff      <= mcnt_in;
         sum_ff       <= sum_in;
         prev_err_ff  <= prev_err_in;
         prev_out_ff  <= prev_out_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff       <= err_in;
      restart_ff   <= restart_in;
      derr_ff      <= derr_in;
      acc_ff       <= acc_in;
      o_ff         <= o_in;
      lim_ff       <= lim_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      drive_ff     <= drive_in;
      slw_ff       <= slw_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_lim_ff   <= rsp_lim_in;
      rsp_slw_ff   <= rsp_slw_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive     = rsp_drive_ff;
   assign rsp_limit_hit = rsp_lim_ff;
   assign rsp_slew_hit  = rsp_slw_ff;

   `PID_AWS_ASSERT(a_div_gain_nonzero, clock, reset, div_start |-> (ki_ff != '0), "divide started with zero integral gain")
   `PID_AWS_ASSERT(a_div_in_flight, clock, reset, (state_ff == ST_DIV) |-> (div_stat.busy || div_stat.done), "waiting on an idle divider")
   `PID_AWS_ASSERT(a_prev_out_hold, clock, reset, (state_ff != ST_SLEW && state_ff != ST_SUM) |=> $stable(prev_out_ff), "last output changed outside update")
   `PID_AWS_ASSERT(a_restart_zero, clock, reset, (state_ff == ST_DONE && restart_ff) |-> (drive_ff == '0 && !lim_ff && !slw_ff), "restart result not cleared")
   `PID_AWS_ASSERT_NR(a_reset_idle, clock, reset |=> (state_ff == ST_IDLE && !rsp_valid_ff), "reset did not idle the sequencer")

endmodule

// ===== hdl/pid_aws_mul.sv =====
// Registered signed multiplier: one operand times one 16-bit gain half
module pid_aws_mul (
   input  logic                                   clock,
   input  logic signed [pid_aws_pkg::MUL_A_W-1:0] mul_a,
   input  logic        [pid_aws_pkg::HALF_W-1:0]  mul_b,
   output logic signed [pid_aws_pkg::PROD_W-1:0]  prod
);
   import pid_aws_pkg::*;

   logic signed [HALF_W:0]   b_s;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;

   assign b_s     = {1'b0, mul_b};
   assign prod_in = mul_a * b_s;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== hdl/pid_aws_div.sv =====
// Bit-serial restoring divider for the anti-windup scale, capped quotient
`include "pid_controller_antiwindup_slew_unit_assert.svh"
module pid_aws_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [pid_aws_pkg::ACC_W-1:0]         magnitude,
   input  logic [pid_aws_pkg::GAIN_W-1:0]        divisor,
   output logic [pid_aws_pkg::QUO_W-1:0]         quotient,
   output pid_aws_pkg::div_status_type           status
);
   import pid_aws_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic [GAIN_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0]  shreg_ff, shreg_in;
   logic [HI_W-1:0]   hi;
   logic [GAIN_W:0]   rem2;
   logic [GAIN_W:0]   rem_sub;
   logic              fits;
   logic              ge;

   // Dividend is magnitude << 16; its bits above the quotient width seed the remainder
   assign hi      = magnitude[ACC_W-1:LOW_MAG_W];
   assign fits    = hi < HI_W'(divisor);
   assign rem2    = {rem_ff, shreg_ff[QUO_W-1]};
   assign rem_sub = rem2 - {1'b0, divisor};
   assign ge      = rem2 >= {1'b0, divisor};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      shreg_in = shreg_ff;
      if (start) begin
         if (fits) begin
            busy_in  = 1'b1;
            cnt_in   = QCNT_W'(QUO_W);
            rem_in   = hi[GAIN_W-1:0];
            shreg_in = {magnitude[LOW_MAG_W-1:0], {FRAC_W{1'b0}}};
         end else begin
            // quotient would not fit: saturate at once
            busy_in  = 1'b0;
            done_in  = 1'b1;
            shreg_in = SCALE_CAP;
         end
      end else if (busy_ff) begin
         rem_in   = ge ? rem_sub[GAIN_W-1:0] : rem2[GAIN_W-1:0];
         shreg_in = {shreg_ff[QUO_W-2:0], ge};
         cnt_in   = cnt_ff - QCNT_W'(1);
         if (cnt_ff == QCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      shreg_ff <= shreg_in;
   end

   assign quotient    = (shreg_ff > SCALE_CAP) ? SCALE_CAP : shreg_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   `PID_AWS_ASSERT(a_div_start_runs, clock, reset, start |=> (busy_ff || done_ff), "divider start lost")
   `PID_AWS_ASSERT(a_div_cnt_live, clock, reset, busy_ff |-> (cnt_ff != '0), "divider count ran out while busy")
   `PID_AWS_ASSERT(a_div_done_idle, clock, reset, done_ff |-> !busy_ff, "divider done while still busy")

endmodule

// ===== tb/pid_controller_antiwindup_slew_unit_tb.sv =====
// Self-checking testbench for the PID controller with anti-windup and slew limit
`timescale 1ns / 100ps

module pid_controller_antiwindup_slew_unit_tb;
   import pid_aws_pkg::*;

   typedef struct packed {
      logic signed [IN_W-1:0] setpoint;
      logic signed [IN_W-1:0] measurement;
      logic                   restart;
   } pid_sample_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] drive;
      logic                    limit_hit;
      logic                    slew_hit;
   } pid_result_type;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;
   localparam longint SUM_HI      = 64'sd2147483647;
   localparam longint SUM_LO      = -64'sd2147483648;
   localparam longint DRIVE_HI    = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
   localparam longint DRIVE_LO    = -DRIVE_HI - 64'sd1;
   localparam bit [63:0] UNWIND_CAP = 64'h2_0000_0000;
   localparam int LONG_HOLD_CYCLES = 400;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [IN_W-1:0]   req_setpoint = '0;
   logic signed [IN_W-1:0]   req_measurement = '0;
   logic                     req_restart = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [OUT_W-1:0]  rsp_drive;
   logic                     rsp_limit_hit;
   logic                     rsp_slew_hit;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;

   // controller copy: registers and loop state
   bit [31:0] kp_gain, ki_gain, kd_gain;
   int        max_lim, min_lim, slew_lim;
   longint    integ_sum, last_err, last_drive;

   pid_sample_type sample_q[$];
   pid_result_type expected_drive_q[$];
   pid_sample_type offered;
   pid_result_type want;
   int          error_count = 0;
   int          send_wait = 0;
   int          recv_wait = 0;
   int          hold_requests = 0;
   int          hold_served = 0;
   bit          idling_on = 1'b1;

   pid_controller_antiwindup_slew_unit dut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic pid_result_type pid_predict_step(input pid_sample_type s);
      longint    err, o, excess, q, kp_l, ki_l, kd_l;
      bit [63:0] mag, quo, ki_u;
      pid_result_type r;
      r = '0;
      if (s.restart) begin
         integ_sum = 0;
         last_err = 0;
         last_drive = 0;
         return r;
      end
      kp_l = longint'(kp_gain);
      ki_l = longint'(ki_gain);
      kd_l = longint'(kd_gain);
      ki_u = 64'(ki_gain);
      err = longint'(s.setpoint) - longint'(s.measurement);
      integ_sum = (ki_gain != 0) ? clip(integ_sum + err, SUM_LO, SUM_HI) : 64'sd0;
      o = ((err * kp_l) >>> 16) + ((integ_sum * ki_l) >>> 16)
        + (((err - last_err) * kd_l) >>> 16);
      if (ki_gain != 0) begin
         excess = 0;
         // max limit wins even when min is above max
         if (o > max_lim) begin
            excess = o - max_lim;
            o = max_lim;
            r.limit_hit = 1'b1;
         end else if (o < min_lim) begin
            excess = o - min_lim;
            o = min_lim;
            r.limit_hit = 1'b1;
         end
         if (r.limit_hit) begin
            mag = (excess < 0) ? -excess : excess;
            quo = (mag << 16) / ki_u;
            if (quo > UNWIND_CAP) quo = UNWIND_CAP;
            q = quo;
            integ_sum = clip(integ_sum - ((excess < 0) ? -q : q), SUM_LO, SUM_HI);
         end
      end else if (o > max_lim) begin
         o = max_lim;
         r.limit_hit = 1'b1;
      end else if (-o > max_lim) begin
         o = -max_lim;
         r.limit_hit = 1'b1;
      end
      last_err = err;
      if (o - last_drive > slew_lim) begin
         o = last_drive + slew_lim;
         r.slew_hit = 1'b1;
      end
      if (o - last_drive < -slew_lim) begin
         o = last_drive - slew_lim;
         r.slew_hit = 1'b1;
      end
      o = clip(o, DRIVE_LO, DRIVE_HI);
      last_drive = o;
      r.drive = o[OUT_W-1:0];
      return r;
   endfunction

   // Driver: offer queued samples, hold payload until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         if (req_valid && req_ready) expected_drive_q.push_back(pid_predict_step(offered));
         if (!req_valid || req_ready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (idling_on && $urandom_range(0, 9) == 0) begin
               send_wait = $urandom_range(0, 17);
               req_valid <= 1'b0;
            end else if (sample_q.size() > 0) begin
               offered = sample_q.pop_front();
               req_valid <= 1'b1;
               req_setpoint <= offered.setpoint;
               req_measurement <= offered.measurement;
               req_restart <= offered.restart;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each response transaction against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_drive_q.size() == 0) begin
               $error("unexpected response: drive %0d", rsp_drive);
               error_count++;
            end else begin
               want = expected_drive_q.pop_front();
               if (rsp_drive !== want.drive) begin
                  $error("drive: expected %0d, actual %0d", want.drive, rsp_drive);
                  error_count++;
               end
               if (rsp_limit_hit !== want.limit_hit) begin
                  $error("limit_hit: expected %0b, actual %0b", want.limit_hit, rsp_limit_hit);
                  error_count++;
               end
               if (rsp_slew_hit !== want.slew_hit) begin
                  $error("slew_hit: expected %0b, actual %0b", want.slew_hit, rsp_slew_hit);
                  error_count++;
               end
            end
         end
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            recv_wait = LONG_HOLD_CYCLES;
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 9) == 0) begin
            recv_wait = $urandom_range(0, 17);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_KP:         kp_gain = data;
         CSR_KI_TS:      ki_gain = data;
         CSR_KD_F:       kd_gain = data;
         CSR_MAX_OUTPUT: max_lim = int'(data[14:0]);
         CSR_MIN_OUTPUT: min_lim = int'($signed(data[15:0]));
         CSR_SLEW_STEP:  slew_lim = int'(data[14:0]);
         default: ;
      endcase
   endtask

   task automatic load_config(input logic [31:0] kp, input logic [31:0] ki,
                              input logic [31:0] kd, input logic [31:0] hi,
                              input logic [31:0] lo, input logic [31:0] step);
      write_csr(CSR_KP, kp);
      write_csr(CSR_KI_TS, ki);
      write_csr(CSR_KD_F, kd);
      write_csr(CSR_MAX_OUTPUT, hi);
      write_csr(CSR_MIN_OUTPUT, lo);
      write_csr(CSR_SLEW_STEP, step);
   endtask

   task automatic push_sample(input int sp, input int pv, input bit rs);
      pid_sample_type s;
      s.setpoint = sp[IN_W-1:0];
      s.measurement = pv[IN_W-1:0];
      s.restart = rs;
      sample_q.push_back(s);
   endtask

   // Hold the sender until every prediction has been answered; sample away from the edge
   task automatic drain();
      while (sample_q.size() != 0 || req_valid || expected_drive_q.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_gain();
      case ($urandom_range(0, 6))
         0: return 32'd0;
         1: return $urandom_range(1, 32'h400);
         2: return $urandom_range(32'h2000, 32'h4_0000);
         3: return $urandom_range(32'h1_0000, 32'h40_0000);
         4: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_limit(input bit signed_lim);
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(0, 4))
         0: w[15:0] = 16'h0000;
         1: w[15:0] = 16'h7FFF;
         2: w[15:0] = signed_lim ? 16'h8000 : 16'($urandom_range(0, 300));
         3: w[15:0] = signed_lim ? 16'(-$urandom_range(0, 3000)) : 16'($urandom_range(0, 3000));
         default: ;
      endcase
      return w;
   endfunction

   task automatic push_random_sample();
      int sp, mode;
      mode = $urandom_range(0, 19);
      sp = int'($signed(16'($urandom)));
      if (mode == 0)
         push_sample(sp, $urandom, 1'b1);
      else if (mode < 11)
         push_sample(sp, int'(clip(sp + int'($urandom_range(0, 600)) - 300,
                                   -32768, 32767)), 1'b0);
      else if (mode < 14)
         push_sample(sp, int'(clip(sp + int'($urandom_range(0, 16000)) - 8000,
                                   -32768, 32767)), 1'b0);
      else
         push_sample(sp, $urandom, 1'b0);
   endtask

   initial begin
      int phase, n;
      kp_gain = KP_RST;
      ki_gain = KI_TS_RST;
      kd_gain = KD_F_RST;
      max_lim = int'(MAX_OUTPUT_RST);
      min_lim = int'(MIN_OUTPUT_RST);
      slew_lim = int'(SLEW_STEP_RST);
      integ_sum = 0;
      last_err = 0;
      last_drive = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: all gains zero
      push_sample(32767, -32768, 1'b0);
      push_sample(-32768, 32767, 1'b0);
      push_sample(0, 0, 1'b1);
      drain();

      // proportional and derivative only: symmetric clamp, wide slew
      load_config(32'h1_0000, 32'd0, 32'h1_0000, 32'hFFFF_FFFF, 32'h0000_8000, 32'hFFFF_7FFF);
      push_sample(32767, -32768, 1'b0);
      push_sample(-32768, 32767, 1'b0);
      push_sample(100, 0, 1'b0);
      push_sample(100, 0, 1'b0);
      push_sample(-5, 7, 1'b1);
      drain();

      // zero limit and zero slew step
      load_config(32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_8000, 32'h0, 32'h0);
      push_sample(1000, 0, 1'b0);
      push_sample(-1000, 0, 1'b0);
      drain();

      // tiny integral gain: unwind quotient hits the cap, sum saturates both ways
      load_config(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd100, 32'hFFFF_FF9C, 32'h7FFF);
      push_sample(32767, -32768, 1'b0);
      push_sample(-32768, 32767, 1'b0);
      push_sample(0, 0, 1'b0);
      push_sample(5, 0, 1'b0);
      push_sample(0, 0, 1'b1);
      drain();

      // full integral gain with min above max; unknown indexes are ignored
      load_config(32'd0, 32'hFFFF_FFFF, 32'd0, 32'd10, 32'd100, 32'd25);
      write_csr(CSR_SPARE_A, 32'hDEAD_BEEF);
      write_csr(CSR_SPARE_B, 32'h0000_0001);
      push_sample(1, 0, 1'b0);
      push_sample(0, 0, 1'b0);
      push_sample(-1, 0, 1'b0);
      push_sample(-3, 0, 1'b0);
      drain();

      for (phase = 0; phase < 8; phase++) begin
         idling_on = (phase != 3) && (phase != 7);
         load_config(pick_gain(), pick_gain(), pick_gain(), pick_limit(1'b0),
                     pick_limit(1'b1), pick_limit(1'b0));
         // stall the receiver long enough to back up the input
         if (phase == 2) hold_requests++;
         for (n = 0; n < 70; n++) push_random_sample();
         drain();
      end

      repeat (60) @(posedge clock);
      if (error_count == 0 && expected_drive_q.size() == 0)
         $display("** pid_controller_antiwindup_slew_unit: PASSED **");
      else
         $display("** pid_controller_antiwindup_slew_unit: FAILED **");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("** pid_controller_antiwindup_slew_unit: FAILED **");
      $finish;
   end

endmodule
